// ----- hw/rtl/fmap_pkg.sv -----
package fmap_pkg;

    localparam int SLOT_W = 5;
    localparam int WORD_W = 32;

    // One fragment of the map: [start, start + len), owned by a node slot
    typedef struct packed {
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] len;
        logic [SLOT_W-1:0] owner;
    } frag_t;

    // How a new range relates to one stored fragment
    typedef enum logic [2:0] {
        OV_NONE,
        OV_TOTAL,
        OV_LEFT,
        OV_RIGHT,
        OV_SPLIT
    } ov_t;

    localparam logic KIND_DEAD = 1'b0;
    localparam logic KIND_SUM  = 1'b1;

    // Classify old fragment [s2, s2+len) against new range [s1, e1), exclusive ends
    function automatic ov_t ov_classify(
        input logic [WORD_W-1:0] s2,
        input logic [WORD_W-1:0] len,
        input logic [WORD_W:0]   s1,
        input logic [WORD_W:0]   e1
    );
        logic [WORD_W:0] e2;
        logic [WORD_W:0] s2x;
        ov_t             res;
        s2x = {1'b0, s2};
        e2  = s2x + {1'b0, len};
        if (s1 <= s2x && e1 >= e2)
            res = OV_TOTAL;
        else if (s1 <= s2x && e1 < e2 && e1 > s2x)
            res = OV_LEFT;
        else if (s1 > s2x && s1 < e2 && e1 >= e2)
            res = OV_RIGHT;
        else if (s1 > s2x && e1 < e2)
            res = OV_SPLIT;
        else
            res = OV_NONE;
        return res;
    endfunction

endpackage

// ----- hw/rtl/file_fragment_map_engine_unit.sv -----
// Fragment map engine. Holds one file's fragment map, ordered by start offset,
// in a double-banked fragment memory and a per-node reference count memory.
// A write item (func 0) overlays its range on the map; one with a zero byte
// count clears the map instead. A count pass reads every stored fragment to
// check for room. A rewrite pass then copies the trimmed survivors into the
// other bank and merges in the new fragment and any split tail. Each dropped
// fragment has its reference count updated, and the new node and a split tail
// each gain a reference. Each result item waits at the output register while
// out_ready is low. Clear and file deletion drop every fragment in turn.
// Items are processed one at a time; in_ready is high only while the engine
// is idle. Each item yields zero or more node invalidation results (kind 0, at
// most MAX_FRAGS) followed by one summary result (kind 1, last 1). No clearing
// pass is needed after reset.
module file_fragment_map_engine_unit
    import fmap_pkg::*;
#(
    parameter int MAX_FRAGS = 32,
    parameter int MAX_NODES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [4:0]  node_slot,
    input  logic [31:0] start_offset,
    input  logic [31:0] byte_count,
    input  logic [31:0] recorded_size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [4:0]  dead_slot,
    output logic [31:0] current_size,
    output logic [5:0]  frags_in_use,
    output logic        overflow,
    output logic        last
);

    localparam int FI_W  = $clog2(MAX_FRAGS);
    localparam int FA_W  = FI_W + 1;
    localparam int CNT_W = $clog2(MAX_FRAGS + 1);
    localparam int CK_W  = CNT_W + 2;
    localparam int NI_W  = $clog2(MAX_NODES);
    localparam int RW    = $clog2(MAX_FRAGS + 1);
    localparam logic [WORD_W:0] TOP = {1'b1, {WORD_W{1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE, S_CNT_RD, S_CNT_EV, S_CHECK,
        S_OV_RD, S_OV_EV, S_OV_PUT, S_OV_NEXT, S_OV_END,
        S_CLR_RD, S_CLR_EV, S_CLR_NEXT,
        S_DR_RD, S_DR_EV, S_AR_NEW, S_AR_RD, S_AR_EV,
        S_PREV, S_FIN, S_SUM, S_EMIT
    } state_t;

    // Memories
    frag_t          frag_mem [2**FA_W];
    logic [RW-1:0]  refs_mem [MAX_NODES];

    state_t          state_reg, ret_reg;
    logic            bank_reg;
    logic [CNT_W-1:0] count_reg, i_reg, w_reg, del_reg, spl_reg, kcnt_reg;
    frag_t           rd_q;
    logic [RW-1:0]   refs_q;

    logic            fw_en_reg;
    logic [FA_W-1:0] fw_addr_reg;
    frag_t           fw_data_reg;
    logic            rw_en_reg;
    logic [NI_W-1:0] rw_addr_reg;
    logic [RW-1:0]   rw_data_reg;
    logic [NI_W-1:0] refs_addr_reg;

    logic [MAX_NODES-1:0] refs_vld_reg;
    logic [MAX_NODES-1:0] live_reg;

    // Item being processed
    logic            is_del_reg;
    logic [4:0]      slot_reg;
    logic [WORD_W-1:0] s1_reg;
    logic [WORD_W:0] e1_reg;
    logic [31:0]     fsize_reg;
    logic            szero_reg;
    logic            ovf_reg;

    // Rewrite pass state
    frag_t           cur_reg;
    logic            cur_split_reg;
    frag_t           tail_reg;
    logic            have_tail_reg, tail_pend_reg, new_done_reg;
    logic [4:0]      drop_reg;

    // Previous node record
    logic [4:0]      prev_slot_reg;
    logic            prev_zero_reg, have_prev_reg;
    logic [31:0]     prev_fsize_reg;

    // Pending result
    logic            em_kind_reg;
    logic [4:0]      em_slot_reg;
    logic [31:0]     em_size_reg;
    logic [5:0]      em_frags_reg;
    logic            em_ovf_reg;

    logic            out_valid_reg;
    logic            kind_reg, overflow_reg, last_reg;
    logic [4:0]      dead_slot_reg;
    logic [31:0]     current_size_reg;
    logic [5:0]      frags_in_use_reg;

    // Combinational helpers
    ov_t             cls;
    logic [WORD_W:0] e2;
    frag_t           ins_frag;
    logic [RW-1:0]   refs_val;
    logic [CK_W-1:0] need, room;
    logic [CNT_W-1:0] i_inc;
    logic            in_slot_ok, prev_ok, drop_ok, kroom;
    logic [31:0]     cur_size;

    assign cls   = ov_classify(rd_q.start, rd_q.len, {1'b0, s1_reg}, e1_reg);
    assign e2    = {1'b0, rd_q.start} + {1'b0, rd_q.len};
    assign ins_frag.start = s1_reg;
    assign ins_frag.len   = WORD_W'(e1_reg - {1'b0, s1_reg});
    assign ins_frag.owner = slot_reg;
    assign refs_val = refs_vld_reg[refs_addr_reg] ? refs_q : '0;
    assign need  = CK_W'(count_reg) + CK_W'(spl_reg) + CK_W'(1);
    assign room  = CK_W'(del_reg) + CK_W'(MAX_FRAGS);
    assign i_inc = i_reg + CNT_W'(1);
    assign in_slot_ok = 32'(node_slot) < 32'(MAX_NODES);
    assign prev_ok    = 32'(prev_slot_reg) < 32'(MAX_NODES);
    assign drop_ok    = 32'(drop_reg) < 32'(MAX_NODES);
    assign kroom      = kcnt_reg < CNT_W'(MAX_FRAGS);
    assign cur_size   = (have_prev_reg && prev_ok && live_reg[NI_W'(prev_slot_reg)])
                        ? prev_fsize_reg : 32'd0;

    // Fragment memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (fw_en_reg)
        begin
            frag_mem[fw_addr_reg] <= fw_data_reg;
        end
        rd_q <= frag_mem[{bank_reg, i_reg[FI_W-1:0]}];
    end

    // Reference count memory, with forwarding of a write in flight
    always_ff @(posedge clk)
    begin
        if (rw_en_reg)
        begin
            refs_mem[rw_addr_reg] <= rw_data_reg;
        end
        if (rw_en_reg && rw_addr_reg == refs_addr_reg)
            refs_q <= rw_data_reg;
        else
            refs_q <= refs_mem[refs_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            bank_reg       <= 1'b0;
            count_reg      <= '0;
            i_reg          <= '0;
            w_reg          <= '0;
            del_reg        <= '0;
            spl_reg        <= '0;
            kcnt_reg       <= '0;
            fw_en_reg      <= 1'b0;
            rw_en_reg      <= 1'b0;
            refs_vld_reg   <= '0;
            live_reg       <= '0;
            prev_slot_reg  <= '0;
            prev_zero_reg  <= 1'b0;
            have_prev_reg  <= 1'b0;
            prev_fsize_reg <= '0;
            out_valid_reg  <= 1'b0;
            have_tail_reg  <= 1'b0;
            tail_pend_reg  <= 1'b0;
            new_done_reg   <= 1'b0;
            ovf_reg        <= 1'b0;
            is_del_reg     <= 1'b0;
        end
        else
        begin
            // Write strobes are registered from the current state
            fw_en_reg <= (state_reg == S_OV_PUT)
                         || ((state_reg == S_OV_END) && (!new_done_reg || tail_pend_reg));
            rw_en_reg <= ((state_reg == S_DR_EV) && drop_ok && (refs_val != '0))
                         || (state_reg == S_AR_EV);

            if (state_reg == S_EMIT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        is_del_reg <= func;
                        slot_reg   <= node_slot;
                        s1_reg     <= start_offset;
                        if (33'(start_offset) + 33'(byte_count) > TOP)
                            e1_reg <= TOP;
                        else
                            e1_reg <= 33'(start_offset) + 33'(byte_count);
                        fsize_reg  <= recorded_size;
                        szero_reg  <= (byte_count == '0);
                        i_reg      <= '0;
                        kcnt_reg   <= '0;
                        del_reg    <= '0;
                        spl_reg    <= '0;
                        ovf_reg    <= !func && !in_slot_ok;
                        if (func)
                            state_reg <= (count_reg == '0) ? S_SUM : S_CLR_RD;
                        else if (!in_slot_ok)
                            state_reg <= S_SUM;
                        else if (byte_count == '0)
                            state_reg <= (count_reg == '0) ? S_PREV : S_CLR_RD;
                        else
                            state_reg <= (count_reg == '0) ? S_CHECK : S_CNT_RD;
                    end
                end

                // Count pass: how many fragments go and how many split
                S_CNT_RD:
                    state_reg <= S_CNT_EV;
                S_CNT_EV:
                begin
                    if (cls == OV_TOTAL)
                        del_reg <= del_reg + CNT_W'(1);
                    else if (cls == OV_SPLIT)
                        spl_reg <= spl_reg + CNT_W'(1);
                    i_reg     <= i_inc;
                    state_reg <= (i_inc < count_reg) ? S_CNT_RD : S_CHECK;
                end
                S_CHECK:
                begin
                    if (need > room)
                    begin
                        ovf_reg   <= 1'b1;
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        i_reg         <= '0;
                        w_reg         <= '0;
                        new_done_reg  <= 1'b0;
                        tail_pend_reg <= 1'b0;
                        have_tail_reg <= 1'b0;
                        state_reg     <= (count_reg == '0) ? S_OV_END : S_OV_RD;
                    end
                end

                // Rewrite pass into the other bank
                S_OV_RD:
                    state_reg <= S_OV_EV;
                S_OV_EV:
                begin
                    case (cls)
                        OV_TOTAL:
                        begin
                            drop_reg      <= rd_q.owner;
                            refs_addr_reg <= NI_W'(rd_q.owner);
                            ret_reg       <= S_OV_NEXT;
                            state_reg     <= S_DR_RD;
                        end
                        OV_LEFT:
                        begin
                            cur_reg       <= {e1_reg[WORD_W-1:0], WORD_W'(e2 - e1_reg),
                                              rd_q.owner};
                            cur_split_reg <= 1'b0;
                            state_reg     <= S_OV_PUT;
                        end
                        OV_RIGHT:
                        begin
                            cur_reg       <= {rd_q.start, s1_reg - rd_q.start, rd_q.owner};
                            cur_split_reg <= 1'b0;
                            state_reg     <= S_OV_PUT;
                        end
                        OV_SPLIT:
                        begin
                            cur_reg        <= {rd_q.start, s1_reg - rd_q.start, rd_q.owner};
                            cur_split_reg  <= 1'b1;
                            tail_reg.start <= e1_reg[WORD_W-1:0];
                            tail_reg.len   <= WORD_W'(e2 - e1_reg);
                            tail_reg.owner <= rd_q.owner;
                            have_tail_reg  <= 1'b1;
                            state_reg      <= S_OV_PUT;
                        end
                        default:
                        begin
                            cur_reg       <= rd_q;
                            cur_split_reg <= 1'b0;
                            state_reg     <= S_OV_PUT;
                        end
                    endcase
                end
                S_OV_PUT:
                begin
                    fw_addr_reg <= {~bank_reg, w_reg[FI_W-1:0]};
                    w_reg       <= w_reg + CNT_W'(1);
                    // Merge: new fragment before the first later start, then the tail
                    if (!new_done_reg && cur_reg.start > s1_reg)
                    begin
                        fw_data_reg  <= ins_frag;
                        new_done_reg <= 1'b1;
                    end
                    else if (tail_pend_reg && {1'b0, cur_reg.start} > e1_reg)
                    begin
                        fw_data_reg   <= tail_reg;
                        tail_pend_reg <= 1'b0;
                    end
                    else
                    begin
                        fw_data_reg <= cur_reg;
                        if (cur_split_reg)
                            tail_pend_reg <= 1'b1;
                        state_reg <= S_OV_NEXT;
                    end
                end
                S_OV_NEXT:
                begin
                    i_reg     <= i_inc;
                    state_reg <= (i_inc < count_reg) ? S_OV_RD : S_OV_END;
                end
                S_OV_END:
                begin
                    if (!new_done_reg)
                    begin
                        fw_addr_reg  <= {~bank_reg, w_reg[FI_W-1:0]};
                        fw_data_reg  <= ins_frag;
                        w_reg        <= w_reg + CNT_W'(1);
                        new_done_reg <= 1'b1;
                    end
                    else if (tail_pend_reg)
                    begin
                        fw_addr_reg   <= {~bank_reg, w_reg[FI_W-1:0]};
                        fw_data_reg   <= tail_reg;
                        w_reg         <= w_reg + CNT_W'(1);
                        tail_pend_reg <= 1'b0;
                    end
                    else
                    begin
                        bank_reg  <= ~bank_reg;
                        count_reg <= w_reg;
                        i_reg     <= '0;
                        if (have_tail_reg)
                        begin
                            refs_addr_reg <= NI_W'(tail_reg.owner);
                            ret_reg       <= S_AR_NEW;
                            state_reg     <= S_AR_RD;
                        end
                        else
                            state_reg <= S_AR_NEW;
                    end
                end

                // Clear pass: drop every fragment in table order
                S_CLR_RD:
                    state_reg <= S_CLR_EV;
                S_CLR_EV:
                begin
                    drop_reg      <= rd_q.owner;
                    refs_addr_reg <= NI_W'(rd_q.owner);
                    ret_reg       <= S_CLR_NEXT;
                    state_reg     <= S_DR_RD;
                end
                S_CLR_NEXT:
                begin
                    if (i_inc < count_reg)
                    begin
                        i_reg     <= i_inc;
                        state_reg <= S_CLR_RD;
                    end
                    else
                    begin
                        count_reg <= '0;
                        i_reg     <= '0;
                        state_reg <= is_del_reg ? S_SUM : S_PREV;
                    end
                end

                // Drop one reference; a count reaching zero kills the node
                S_DR_RD:
                    state_reg <= S_DR_EV;
                S_DR_EV:
                begin
                    if (drop_ok && refs_val != '0)
                    begin
                        rw_addr_reg <= refs_addr_reg;
                        rw_data_reg <= refs_val - RW'(1);
                        refs_vld_reg[refs_addr_reg] <= 1'b1;
                        if (refs_val == RW'(1))
                        begin
                            live_reg[refs_addr_reg] <= 1'b0;
                            if (kroom)
                            begin
                                kcnt_reg     <= kcnt_reg + CNT_W'(1);
                                em_kind_reg  <= KIND_DEAD;
                                em_slot_reg  <= drop_reg;
                                em_size_reg  <= '0;
                                em_frags_reg <= '0;
                                em_ovf_reg   <= 1'b0;
                                state_reg    <= S_EMIT;
                            end
                            else
                                state_reg <= ret_reg;
                        end
                        else
                            state_reg <= ret_reg;
                    end
                    else
                        state_reg <= ret_reg;
                end

                // Add one reference to the new node or to a split tail's owner
                S_AR_NEW:
                begin
                    refs_addr_reg <= NI_W'(slot_reg);
                    ret_reg       <= S_PREV;
                    state_reg     <= S_AR_RD;
                end
                S_AR_RD:
                    state_reg <= S_AR_EV;
                S_AR_EV:
                begin
                    rw_addr_reg <= refs_addr_reg;
                    rw_data_reg <= refs_val + RW'(1);
                    refs_vld_reg[refs_addr_reg] <= 1'b1;
                    state_reg   <= ret_reg;
                end

                // Kill a live zero-size previous node
                S_PREV:
                begin
                    if (have_prev_reg && prev_zero_reg && prev_ok
                        && live_reg[NI_W'(prev_slot_reg)])
                    begin
                        live_reg[NI_W'(prev_slot_reg)] <= 1'b0;
                        if (kroom)
                        begin
                            kcnt_reg     <= kcnt_reg + CNT_W'(1);
                            em_kind_reg  <= KIND_DEAD;
                            em_slot_reg  <= prev_slot_reg;
                            em_size_reg  <= '0;
                            em_frags_reg <= '0;
                            em_ovf_reg   <= 1'b0;
                            ret_reg      <= S_FIN;
                            state_reg    <= S_EMIT;
                        end
                        else
                            state_reg <= S_FIN;
                    end
                    else
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    live_reg[NI_W'(slot_reg)] <= 1'b1;
                    prev_slot_reg  <= slot_reg;
                    prev_zero_reg  <= szero_reg && (fsize_reg == '0);
                    have_prev_reg  <= 1'b1;
                    prev_fsize_reg <= fsize_reg;
                    state_reg      <= S_SUM;
                end

                S_SUM:
                begin
                    em_kind_reg  <= KIND_SUM;
                    em_slot_reg  <= '0;
                    em_size_reg  <= cur_size;
                    em_frags_reg <= 6'(count_reg);
                    em_ovf_reg   <= ovf_reg;
                    ret_reg      <= S_IDLE;
                    state_reg    <= S_EMIT;
                end

                // Hold until the output register is free
                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        kind_reg         <= em_kind_reg;
                        dead_slot_reg    <= em_slot_reg;
                        current_size_reg <= em_size_reg;
                        frags_in_use_reg <= em_frags_reg;
                        overflow_reg     <= em_ovf_reg;
                        last_reg         <= (em_kind_reg == KIND_SUM);
                        state_reg        <= ret_reg;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign dead_slot    = dead_slot_reg;
    assign current_size = current_size_reg;
    assign frags_in_use = frags_in_use_reg;
    assign overflow     = overflow_reg;
    assign last         = last_reg;

endmodule

// ----- verif/tb_file_fragment_map_engine_unit.sv -----
`timescale 1ns / 100ps

module tb_file_fragment_map_engine_unit;
    import fmap_pkg::*;

    localparam int NFRAG = 32;
    localparam int NNODE = 32;

    typedef struct packed {
        logic        func;
        logic [4:0]  node_slot;
        logic [31:0] start_offset;
        logic [31:0] byte_count;
        logic [31:0] recorded_size;
    } write_item_t;

    typedef struct packed {
        logic        kind;
        logic [4:0]  dead_slot;
        logic [31:0] current_size;
        logic [5:0]  frags_in_use;
        logic        overflow;
        logic        last;
    } map_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic func;
    logic [4:0] node_slot;
    logic [31:0] start_offset;
    logic [31:0] byte_count;
    logic [31:0] recorded_size;
    logic out_valid;
    logic out_ready;
    logic kind;
    logic [4:0] dead_slot;
    logic [31:0] current_size;
    logic [5:0] frags_in_use;
    logic overflow;
    logic last;

    file_fragment_map_engine_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .node_slot(node_slot), .start_offset(start_offset),
        .byte_count(byte_count), .recorded_size(recorded_size),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .dead_slot(dead_slot), .current_size(current_size),
        .frags_in_use(frags_in_use), .overflow(overflow), .last(last)
    );

    // Shadow copy of the fragment map and node bookkeeping
    logic [31:0] map_start [NFRAG];
    logic [31:0] map_len   [NFRAG];
    logic [4:0]  map_owner [NFRAG];
    int          map_count;
    int          slot_refs [NNODE];
    bit          slot_live [NNODE];
    logic [4:0]  last_slot;
    bit          last_was_empty;
    bit          have_last;
    logic [31:0] last_fsize;

    write_item_t pending_items [$];
    map_result_t expected_results [$];
    int fail_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int dead_seen = 0;
    int ovf_seen = 0;

    // Report an invalidated slot; at most NFRAG per item reach the output
    task automatic report_dead(input logic [4:0] s, inout int n);
        map_result_t r;
        slot_live[s] = 0;
        if (n < NFRAG) begin
            r = '0;
            r.kind = KIND_DEAD;
            r.dead_slot = s;
            expected_results.insert(expected_results.size(), r);
            n++;
        end
    endtask

    task automatic release_ref(input logic [4:0] s, inout int n);
        if (slot_refs[s] == 0)
            return;
        slot_refs[s]--;
        if (slot_refs[s] == 0)
            report_dead(s, n);
    endtask

    task automatic place_fragment(input logic [31:0] st, input logic [31:0] ln,
                                  input logic [4:0] ow);
        int pos;
        pos = map_count;
        if (map_count >= NFRAG)
            return;
        for (int i = 0; i < map_count; i++)
            if (map_start[i] > st) begin
                pos = i;
                break;
            end
        for (int i = map_count; i > pos; i--) begin
            map_start[i] = map_start[i-1];
            map_len[i] = map_len[i-1];
            map_owner[i] = map_owner[i-1];
        end
        map_start[pos] = st;
        map_len[pos] = ln;
        map_owner[pos] = ow;
        map_count++;
    endtask

    task automatic empty_map(inout int n);
        for (int i = 0; i < map_count; i++)
            release_ref(map_owner[i], n);
        map_count = 0;
    endtask

    function automatic ov_t relate(int i, logic [32:0] s1, logic [32:0] e1);
        logic [32:0] s2, e2;
        s2 = {1'b0, map_start[i]};
        e2 = s2 + {1'b0, map_len[i]};
        if (s1 <= s2 && e1 >= e2) return OV_TOTAL;
        if (s1 <= s2 && e1 < e2 && e1 > s2) return OV_LEFT;
        if (s1 > s2 && s1 < e2 && e1 >= e2) return OV_RIGHT;
        if (s1 > s2 && e1 < e2) return OV_SPLIT;
        return OV_NONE;
    endfunction

    // Work out the results of one accepted item and advance the shadow map
    task automatic predict_overlay(input write_item_t it);
        int n, dels, spls, w;
        bit ovf, ok, tail_ok;
        logic [32:0] s1, e1, room, s2, e2;
        logic [31:0] t_st, t_ln;
        logic [4:0] t_ow;
        ov_t c;
        map_result_t r;
        n = 0;
        ovf = 0;
        tail_ok = 0;
        if (it.func) begin
            empty_map(n);
        end else begin
            ok = 1;
            if (it.byte_count == 0) begin
                empty_map(n);
            end else begin
                s1 = {1'b0, it.start_offset};
                room = 33'h1_0000_0000 - s1;
                e1 = s1 + (({1'b0, it.byte_count} < room) ? {1'b0, it.byte_count} : room);
                dels = 0;
                spls = 0;
                for (int i = 0; i < map_count; i++) begin
                    c = relate(i, s1, e1);
                    if (c == OV_TOTAL) dels++;
                    else if (c == OV_SPLIT) spls++;
                end
                if (map_count - dels + spls + 1 > NFRAG) begin
                    ok = 0;
                    ovf = 1;
                end else begin
                    w = 0;
                    for (int i = 0; i < map_count; i++) begin
                        c = relate(i, s1, e1);
                        s2 = {1'b0, map_start[i]};
                        e2 = s2 + {1'b0, map_len[i]};
                        if (c == OV_TOTAL) begin
                            release_ref(map_owner[i], n);
                            continue;
                        end
                        if (c == OV_LEFT) begin
                            map_start[i] = e1[31:0];
                            map_len[i] = 32'(e2 - e1);
                        end else if (c == OV_RIGHT) begin
                            map_len[i] = 32'(s1 - s2);
                        end else if (c == OV_SPLIT) begin
                            map_len[i] = 32'(s1 - s2);
                            tail_ok = 1;
                            t_st = e1[31:0];
                            t_ln = 32'(e2 - e1);
                            t_ow = map_owner[i];
                        end
                        map_start[w] = map_start[i];
                        map_len[w] = map_len[i];
                        map_owner[w] = map_owner[i];
                        w++;
                    end
                    map_count = w;
                    if (tail_ok) begin
                        place_fragment(t_st, t_ln, t_ow);
                        slot_refs[t_ow]++;
                    end
                    place_fragment(s1[31:0], 32'(e1 - s1), it.node_slot);
                    slot_refs[it.node_slot]++;
                end
            end
            if (ok) begin
                // A live zero-size previous node dies once a later write lands
                if (have_last && last_was_empty && slot_live[last_slot])
                    report_dead(last_slot, n);
                slot_live[it.node_slot] = 1;
                last_slot = it.node_slot;
                last_was_empty = (it.byte_count == 0 && it.recorded_size == 0);
                have_last = 1;
                last_fsize = it.recorded_size;
            end
        end
        r = '0;
        r.kind = KIND_SUM;
        r.current_size = (have_last && slot_live[last_slot]) ? last_fsize : 32'd0;
        r.frags_in_use = 6'(map_count);
        r.overflow = ovf;
        r.last = 1'b1;
        expected_results.insert(expected_results.size(), r);
    endtask

    function automatic write_item_t make_item(logic f, logic [4:0] s, logic [31:0] o,
                                              logic [31:0] z, logic [31:0] fs);
        write_item_t it;
        it.func = f;
        it.node_slot = s;
        it.start_offset = o;
        it.byte_count = z;
        it.recorded_size = fs;
        return it;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Driver: bursts of items with random gaps; hold payload until accepted
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 0;
            func <= 0;
            node_slot <= 0;
            start_offset <= 0;
            byte_count <= 0;
            recorded_size <= 0;
        end else if (!in_valid || in_ready) begin
            if (in_valid && in_ready) begin
                predict_overlay({func, node_slot, start_offset, byte_count, recorded_size});
                items_sent++;
            end
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 0;
            end else if (pending_items.size() > 0) begin
                write_item_t it;
                it = pending_items.pop_front();
                in_valid <= 1;
                {func, node_slot, start_offset, byte_count, recorded_size} <= it;
                if (burst_left > 0)
                    burst_left--;
                else begin
                    burst_left = $urandom_range(0, 6);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end else begin
                in_valid <= 0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    int stall_phase = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 0;
        end else begin
            stall_phase = (stall_phase + 1) % 64;
            out_ready <= (stall_phase < 24) ? 1'b1 : ($urandom_range(0, 2) != 0);
            if (out_valid && out_ready) begin
                map_result_t got, want;
                got = {kind, dead_slot, current_size, frags_in_use, overflow, last};
                results_seen++;
                if (got.kind == KIND_DEAD) dead_seen++;
                if (got.overflow) ovf_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result %p", got);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("kind exp %0d got %0d", want.kind, got.kind); fail_count++;
                    end
                    if (got.dead_slot !== want.dead_slot) begin
                        $error("dead_slot exp %0d got %0d", want.dead_slot, got.dead_slot);
                        fail_count++;
                    end
                    if (got.current_size !== want.current_size) begin
                        $error("current_size exp %0h got %0h", want.current_size,
                               got.current_size);
                        fail_count++;
                    end
                    if (got.frags_in_use !== want.frags_in_use) begin
                        $error("frags_in_use exp %0d got %0d", want.frags_in_use,
                               got.frags_in_use);
                        fail_count++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $error("overflow exp %0d got %0d", want.overflow, got.overflow);
                        fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last exp %0d got %0d", want.last, got.last); fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int mode;
        logic [31:0] o, z;
        for (int i = 0; i < NNODE; i++) begin
            slot_refs[i] = 0;
            slot_live[i] = 0;
        end
        map_count = 0;
        last_slot = 0;
        last_was_empty = 0;
        have_last = 0;
        last_fsize = 0;
        rst_n = 0;

        // Directed: split, trims, total cover, clip at top, zero-size node, delete
        pending_items.insert(pending_items.size(), make_item(0, 1, 100, 100, 32'hFFFF_FFFF));
        pending_items.insert(pending_items.size(), make_item(0, 2, 120, 10, 500));
        pending_items.insert(pending_items.size(), make_item(0, 3, 90, 20, 600));
        pending_items.insert(pending_items.size(), make_item(0, 4, 190, 50, 700));
        pending_items.insert(pending_items.size(), make_item(0, 5, 80, 200, 0));
        pending_items.insert(pending_items.size(),
                             make_item(0, 6, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1));
        pending_items.insert(pending_items.size(), make_item(0, 31, 32'hFFFF_FFFF, 1, 2));
        pending_items.insert(pending_items.size(), make_item(0, 0, 0, 1, 3));
        pending_items.insert(pending_items.size(), make_item(0, 7, 32'hFFFF_FFFF, 0, 0));
        pending_items.insert(pending_items.size(), make_item(0, 8, 10, 5, 9));
        pending_items.insert(pending_items.size(), make_item(0, 8, 10, 5, 9));
        pending_items.insert(pending_items.size(),
                             make_item(1, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        pending_items.insert(pending_items.size(), make_item(0, 9, 0, 0, 0));
        pending_items.insert(pending_items.size(), make_item(1, 0, 0, 0, 0));
        pending_items.insert(pending_items.size(), make_item(0, 10, 0, 0, 0));
        // Fill the table with many small disjoint fragments, then overflow via splits
        for (int i = 0; i < 32; i++)
            pending_items.insert(pending_items.size(),
                                 make_item(0, 5'(i), 32'(i * 100), 10, 32'(i)));
        pending_items.insert(pending_items.size(), make_item(0, 3, 1003, 2, 77));
        pending_items.insert(pending_items.size(), make_item(0, 4, 0, 32'hFFFF_FFFF, 78));

        // Random: mostly overlapping writes in a narrow window, some wide noise
        for (int i = 0; i < 220; i++) begin
            mode = $urandom_range(0, 99);
            if (mode < 4) begin
                pending_items.insert(pending_items.size(),
                                     make_item(1, 5'($urandom), $urandom, $urandom,
                                               $urandom));
            end else if (mode < 9) begin
                pending_items.insert(pending_items.size(),
                                     make_item(0, 5'($urandom), $urandom, 0,
                                               ($urandom_range(0, 1)) ? 0 : $urandom));
            end else if (mode < 20) begin
                pending_items.insert(pending_items.size(),
                                     make_item(0, 5'($urandom), $urandom, $urandom,
                                               $urandom));
            end else begin
                o = $urandom_range(0, 2000);
                z = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 600 : 40);
                pending_items.insert(pending_items.size(),
                                     make_item(0, 5'($urandom_range(0, 31)), o, z,
                                               $urandom));
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1;

        wait (pending_items.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (400) @(posedge clk);
        $display("Sent %0d items; checked %0d results (%0d invalidations, %0d overflows)",
                 items_sent, results_seen, dead_seen, ovf_seen);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/fmap_pkg.sv
hw/rtl/file_fragment_map_engine_unit.sv
verif/tb_file_fragment_map_engine_unit.sv
